// File: design/leg_pkg.sv
package leg_pkg;

    // fixed-point format of the state words
    localparam int FRAC_BITS  = 24;
    localparam int COUNT_BITS = 20;

    localparam int POS_W   = 32;
    localparam int OPA_W   = 32;
    localparam int OPB_W   = 33;
    localparam int PROD_W  = OPA_W + OPB_W;
    localparam int WIDE_W  = PROD_W + 1;
    localparam int STEP_W  = 3;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 31;
    localparam int DT_W       = 25;
    localparam int GAIN_W     = 31;
    localparam int CNT_CFG_W  = 20;

    localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SIGMA_GAIN    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RHO_GAIN      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BETA_GAIN     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WASHOUT_COUNT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_COUNT  = 3'd5;

    localparam logic [DT_W-1:0]      TIME_STEP_RST     = 25'd167772;
    localparam logic [GAIN_W-1:0]    SIGMA_GAIN_RST    = 31'd167772160;
    localparam logic [GAIN_W-1:0]    RHO_GAIN_RST      = 31'd469762048;
    localparam logic [GAIN_W-1:0]    BETA_GAIN_RST     = 31'd44739243;
    localparam logic [CNT_CFG_W-1:0] WASHOUT_COUNT_RST = 20'd0;
    localparam logic [CNT_CFG_W-1:0] SAMPLE_COUNT_RST  = 20'd1000;

    localparam logic signed [WIDE_W-1:0] SAT_MAX = 66'sd2147483647;
    localparam logic signed [WIDE_W-1:0] SAT_MIN = -66'sd2147483648;

    // multiplier operations of one euler step
    typedef enum logic [2:0] {
        OP_NONE = 3'd0,
        OP_DX   = 3'd1,
        OP_PY   = 3'd2,
        OP_PXY  = 3'd3,
        OP_BZ   = 3'd4,
        OP_UX   = 3'd5,
        OP_UY   = 3'd6,
        OP_UZ   = 3'd7
    } op_t;

    typedef struct packed {
        logic load;
        logic capture;
        op_t  op;
    } dp_cmd_t;

    function automatic op_t op_for_step(input logic [STEP_W-1:0] step);
        op_t op;
        case (step)
            3'd0:    op = OP_DX;
            3'd1:    op = OP_PY;
            3'd2:    op = OP_PXY;
            3'd3:    op = OP_BZ;
            3'd4:    op = OP_UX;
            3'd5:    op = OP_UY;
            3'd6:    op = OP_UZ;
            default: op = OP_NONE;
        endcase
        return op;
    endfunction

    function automatic logic signed [POS_W-1:0] sat32(input logic signed [WIDE_W-1:0] v);
        logic signed [POS_W-1:0] r;
        if (v > SAT_MAX)
        begin
            r = SAT_MAX[POS_W-1:0];
        end
        else if (v < SAT_MIN)
        begin
            r = SAT_MIN[POS_W-1:0];
        end
        else
        begin
            r = v[POS_W-1:0];
        end
        return r;
    endfunction

endpackage

// File: design/leg_in_if.sv
interface leg_in_if;
    logic               valid;
    logic               ready;
    logic               func;
    logic signed [31:0] init_x;
    logic signed [31:0] init_y;
    logic signed [31:0] init_z;

    modport source (output valid, func, init_x, init_y, init_z, input ready);
    modport sink (input valid, func, init_x, init_y, init_z, output ready);
endinterface

// File: design/leg_out_if.sv
interface leg_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic               last_sample;

    modport source (output valid, out_x, out_y, out_z, last_sample, input ready);
    modport sink (input valid, out_x, out_y, out_z, last_sample, output ready);
endinterface

// File: design/leg_datapath.sv
module leg_datapath (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [leg_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [leg_pkg::CFG_DATA_W-1:0]        cfg_data,
    input  leg_pkg::dp_cmd_t                      cmd,
    input  logic signed [leg_pkg::POS_W-1:0]      init_x,
    input  logic signed [leg_pkg::POS_W-1:0]      init_y,
    input  logic signed [leg_pkg::POS_W-1:0]      init_z,
    output logic signed [leg_pkg::POS_W-1:0]      out_x,
    output logic signed [leg_pkg::POS_W-1:0]      out_y,
    output logic signed [leg_pkg::POS_W-1:0]      out_z
);

    logic [leg_pkg::DT_W-1:0]   time_step_reg;
    logic [leg_pkg::GAIN_W-1:0] sigma_gain_reg;
    logic [leg_pkg::GAIN_W-1:0] rho_gain_reg;
    logic [leg_pkg::GAIN_W-1:0] beta_gain_reg;

    logic signed [leg_pkg::POS_W-1:0] x_reg, x_next;
    logic signed [leg_pkg::POS_W-1:0] y_reg, y_next;
    logic signed [leg_pkg::POS_W-1:0] z_reg, z_next;
    logic signed [leg_pkg::POS_W-1:0] dx_reg, dx_next;
    logic signed [leg_pkg::POS_W-1:0] dy_reg, dy_next;
    logic signed [leg_pkg::POS_W-1:0] dz_reg, dz_next;
    logic signed [leg_pkg::POS_W-1:0] t_reg, t_next;
    logic signed [leg_pkg::POS_W-1:0] ox_reg, oy_reg, oz_reg;

    logic signed [leg_pkg::OPA_W-1:0]  mul_a;
    logic signed [leg_pkg::OPB_W-1:0]  mul_b;
    logic signed [leg_pkg::PROD_W-1:0] prod_reg, prod_next;
    leg_pkg::op_t                      wb_op_reg;

    logic signed [leg_pkg::WIDE_W-1:0] shifted;
    logic signed [leg_pkg::POS_W-1:0]  q;
    logic signed [leg_pkg::WIDE_W-1:0] sum_a, sum_b;
    logic signed [leg_pkg::POS_W-1:0]  sum_sat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_step_reg  <= leg_pkg::TIME_STEP_RST;
            sigma_gain_reg <= leg_pkg::SIGMA_GAIN_RST;
            rho_gain_reg   <= leg_pkg::RHO_GAIN_RST;
            beta_gain_reg  <= leg_pkg::BETA_GAIN_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                leg_pkg::REG_TIME_STEP:  time_step_reg  <= cfg_data[leg_pkg::DT_W-1:0];
                leg_pkg::REG_SIGMA_GAIN: sigma_gain_reg <= cfg_data[leg_pkg::GAIN_W-1:0];
                leg_pkg::REG_RHO_GAIN:   rho_gain_reg   <= cfg_data[leg_pkg::GAIN_W-1:0];
                leg_pkg::REG_BETA_GAIN:  beta_gain_reg  <= cfg_data[leg_pkg::GAIN_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // operand select for the shared multiplier
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.op)
            leg_pkg::OP_DX:
            begin
                mul_a = leg_pkg::OPA_W'(sigma_gain_reg);
                mul_b = leg_pkg::OPB_W'(y_reg) - leg_pkg::OPB_W'(x_reg);
            end
            leg_pkg::OP_PY:
            begin
                mul_a = x_reg;
                mul_b = leg_pkg::OPB_W'(rho_gain_reg) - leg_pkg::OPB_W'(z_reg);
            end
            leg_pkg::OP_PXY:
            begin
                mul_a = x_reg;
                mul_b = leg_pkg::OPB_W'(y_reg);
            end
            leg_pkg::OP_BZ:
            begin
                mul_a = leg_pkg::OPA_W'(beta_gain_reg);
                mul_b = leg_pkg::OPB_W'(z_reg);
            end
            leg_pkg::OP_UX:
            begin
                mul_a = leg_pkg::OPA_W'(time_step_reg);
                mul_b = leg_pkg::OPB_W'(dx_reg);
            end
            leg_pkg::OP_UY:
            begin
                mul_a = leg_pkg::OPA_W'(time_step_reg);
                mul_b = leg_pkg::OPB_W'(dy_reg);
            end
            leg_pkg::OP_UZ:
            begin
                mul_a = leg_pkg::OPA_W'(time_step_reg);
                mul_b = leg_pkg::OPB_W'(dz_reg);
            end
            default:
            begin
            end
        endcase
        prod_next = leg_pkg::PROD_W'(mul_a) * leg_pkg::PROD_W'(mul_b);
    end

    // arithmetic shift floors toward minus infinity
    assign shifted = leg_pkg::WIDE_W'(prod_reg) >>> leg_pkg::FRAC_BITS;
    assign q       = leg_pkg::sat32(shifted);

    always_comb
    begin
        sum_a = '0;
        sum_b = '0;
        case (wb_op_reg)
            leg_pkg::OP_PY:
            begin
                sum_a = leg_pkg::WIDE_W'(q);
                sum_b = -leg_pkg::WIDE_W'(y_reg);
            end
            leg_pkg::OP_BZ:
            begin
                sum_a = leg_pkg::WIDE_W'(t_reg);
                sum_b = -leg_pkg::WIDE_W'(q);
            end
            leg_pkg::OP_UX:
            begin
                sum_a = leg_pkg::WIDE_W'(x_reg);
                sum_b = leg_pkg::WIDE_W'(q);
            end
            leg_pkg::OP_UY:
            begin
                sum_a = leg_pkg::WIDE_W'(y_reg);
                sum_b = leg_pkg::WIDE_W'(q);
            end
            leg_pkg::OP_UZ:
            begin
                sum_a = leg_pkg::WIDE_W'(z_reg);
                sum_b = leg_pkg::WIDE_W'(q);
            end
            default:
            begin
            end
        endcase
        sum_sat = leg_pkg::sat32(sum_a + sum_b);
    end

    // writeback of the product issued in the previous cycle, and the state load
    always_comb
    begin
        x_next  = x_reg;
        y_next  = y_reg;
        z_next  = z_reg;
        dx_next = dx_reg;
        dy_next = dy_reg;
        dz_next = dz_reg;
        t_next  = t_reg;
        case (wb_op_reg)
            leg_pkg::OP_DX:  dx_next = q;
            leg_pkg::OP_PY:  dy_next = sum_sat;
            leg_pkg::OP_PXY: t_next  = q;
            leg_pkg::OP_BZ:  dz_next = sum_sat;
            leg_pkg::OP_UX:  x_next  = sum_sat;
            leg_pkg::OP_UY:  y_next  = sum_sat;
            leg_pkg::OP_UZ:  z_next  = sum_sat;
            default:
            begin
            end
        endcase
        if (cmd.load)
        begin
            x_next = init_x;
            y_next = init_y;
            z_next = init_z;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_reg     <= '0;
            y_reg     <= '0;
            z_reg     <= '0;
            wb_op_reg <= leg_pkg::OP_NONE;
        end
        else
        begin
            x_reg     <= x_next;
            y_reg     <= y_next;
            z_reg     <= z_next;
            wb_op_reg <= cmd.op;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        dx_reg   <= dx_next;
        dy_reg   <= dy_next;
        dz_reg   <= dz_next;
        t_reg    <= t_next;
        if (cmd.capture)
        begin
            ox_reg <= x_reg;
            oy_reg <= y_reg;
            oz_reg <= z_reg;
        end
    end

    assign out_x = ox_reg;
    assign out_y = oy_reg;
    assign out_z = oz_reg;

endmodule

// File: design/leg_ctrl.sv
module leg_ctrl #(
    parameter int COUNT_BITS = leg_pkg::COUNT_BITS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [leg_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [leg_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           in_valid,
    input  logic                           in_func,
    output logic                           in_ready,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic                           last_sample,
    output leg_pkg::dp_cmd_t               cmd
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_EMIT = 3'b010,
        ST_STEP = 3'b100
    } state_t;

    state_t state_reg, state_next;
    logic [leg_pkg::STEP_W-1:0]    step_reg, step_next;
    logic [COUNT_BITS-1:0]         washout_left_reg, washout_left_next;
    logic [COUNT_BITS-1:0]         samples_left_reg, samples_left_next;
    logic [leg_pkg::CNT_CFG_W-1:0] washout_count_reg;
    logic [leg_pkg::CNT_CFG_W-1:0] sample_count_reg;
    logic                          out_valid_reg, out_valid_next;
    logic                          last_reg, last_next;
    logic                          accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            washout_count_reg <= leg_pkg::WASHOUT_COUNT_RST;
            sample_count_reg  <= leg_pkg::SAMPLE_COUNT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                leg_pkg::REG_WASHOUT_COUNT:
                    washout_count_reg <= cfg_data[leg_pkg::CNT_CFG_W-1:0];
                leg_pkg::REG_SAMPLE_COUNT:
                    sample_count_reg <= cfg_data[leg_pkg::CNT_CFG_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        state_next        = state_reg;
        step_next         = step_reg;
        washout_left_next = washout_left_reg;
        samples_left_next = samples_left_reg;
        out_valid_next    = out_valid_reg && !out_ready;
        last_next         = last_reg;
        cmd.load          = 1'b0;
        cmd.capture       = 1'b0;
        cmd.op            = leg_pkg::OP_NONE;
        case (state_reg)
            ST_IDLE:
            begin
                step_next = '0;
                if (accept)
                begin
                    if (in_func)
                    begin
                        cmd.load          = 1'b1;
                        washout_left_next = COUNT_BITS'(washout_count_reg);
                        samples_left_next = COUNT_BITS'(sample_count_reg);
                    end
                    else if (washout_left_reg != '0)
                    begin
                        washout_left_next = washout_left_reg - 1'b1;
                        state_next        = ST_STEP;
                    end
                    else if (samples_left_reg != '0)
                    begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_EMIT:
            begin
                // wait here only while the previous sample is still unclaimed
                if (!out_valid_reg || out_ready)
                begin
                    cmd.capture       = 1'b1;
                    out_valid_next    = 1'b1;
                    last_next         = (samples_left_reg == COUNT_BITS'(1));
                    samples_left_next = samples_left_reg - 1'b1;
                    state_next        = ST_STEP;
                end
            end
            ST_STEP:
            begin
                cmd.op    = leg_pkg::op_for_step(step_reg);
                step_next = step_reg + 1'b1;
                if (step_reg == '1)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            step_reg         <= '0;
            washout_left_reg <= '0;
            samples_left_reg <= '0;
            out_valid_reg    <= 1'b0;
            last_reg         <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            step_reg         <= step_next;
            washout_left_reg <= washout_left_next;
            samples_left_reg <= samples_left_next;
            out_valid_reg    <= out_valid_next;
            last_reg         <= last_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign last_sample = last_reg;

    a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("controller state not one-hot");

    a_capture_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |-> (!out_valid_reg || out_ready))
        else $error("sample captured over an unclaimed one");

    a_step_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_STEP && step_reg == '1) |=> (state_reg == ST_IDLE))
        else $error("euler step did not end after the last operation");

    a_restart_load: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && in_func) |=>
            (washout_left_reg == COUNT_BITS'($past(washout_count_reg))
             && samples_left_reg == COUNT_BITS'($past(sample_count_reg))))
        else $error("restart did not rearm the counters");

    a_no_load_in_step: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op != leg_pkg::OP_NONE) |-> !cmd.load)
        else $error("state load during an euler step");

endmodule

// File: design/lorenz_euler_generator.sv
// Lorenz attractor sample generator, forward euler in signed Q8.24.
// item channel: func 1 restarts with init_x/y/z (loads state, rearms the
//   washout and sample counters, no output); func 0 advances one tick.
// result channel: out_x/y/z hold the state before the step of an emitting
//   tick; last_sample marks the final requested sample.
// cfg port: cfg_we, cfg_index, cfg_data write one register per cycle; the
//   user writes only while idle (the block does not enforce it); indexes
//   above 5 are ignored. ticks: a restart or an idle tick leaves the block
//   idle; a washout tick runs one euler step and an emitting tick captures
//   its sample, then runs one. one euler step is seven dependent products
//   through one shared 32x33 multiplier, one issued per cycle, then the
//   write back of the last product; no tick is taken until the step ends.
// the result sits in an output register, so the next tick is taken while
//   a sample waits; an emitting tick then holds before its capture until
//   the receiver takes the earlier sample.
// reset: gains and counts return to their defaults, the state to zero, and
//   the counters to zero, so ticks emit nothing until the first restart.
module lorenz_euler_generator #(
    parameter int COUNT_BITS = leg_pkg::COUNT_BITS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    leg_in_if.sink                         item,
    leg_out_if.source                      result,
    input  logic                           cfg_we,
    input  logic [leg_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [leg_pkg::CFG_DATA_W-1:0] cfg_data
);

    leg_pkg::dp_cmd_t cmd;

    leg_ctrl #(
        .COUNT_BITS (COUNT_BITS)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (item.valid),
        .in_func     (item.func),
        .in_ready    (item.ready),
        .out_valid   (result.valid),
        .out_ready   (result.ready),
        .last_sample (result.last_sample),
        .cmd         (cmd)
    );

    leg_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .init_x    (item.init_x),
        .init_y    (item.init_y),
        .init_z    (item.init_z),
        .out_x     (result.out_x),
        .out_y     (result.out_y),
        .out_z     (result.out_z)
    );

endmodule
